>>> src/ape_pkg.sv
// Shared types and constants for the animation progress easing block.
package ape_pkg;

  localparam int TIME_W = 32;
  localparam int SPAN_W = 16;
  localparam int FRAC_W = 16;
  localparam int T_W    = FRAC_W + 1;
  localparam int E_W    = FRAC_W + 2;
  localparam int DIV_CELLS = FRAC_W;

  localparam logic [T_W-1:0] ONE       = T_W'(1) << FRAC_W;
  localparam logic [E_W-1:0] EASED_MAX = (E_W'(2) << FRAC_W) - E_W'(1);
  // back curve coefficients, 1.70158 and 2.70158 in Q16
  localparam logic [T_W-1:0] C1 = T_W'(111515);
  localparam logic [E_W-1:0] C3 = E_W'(111515) + E_W'(ONE);

  typedef enum logic [1:0] {
    FN_LINEAR    = 2'd0,
    FN_OUT_CUBIC = 2'd1,
    FN_IN_CUBIC  = 2'd2,
    FN_OUT_BACK  = 2'd3
  } ape_func_t;

  typedef struct packed {
    ape_func_t          func;
    logic               animating;
    logic [TIME_W-1:0]  now_time;
    logic [TIME_W-1:0]  start_time;
    logic [SPAN_W-1:0]  span_ms;
  } ape_in_t;

  typedef struct packed {
    logic [T_W-1:0] raw_progress;
    logic [T_W-1:0] eased_progress;
  } ape_out_t;

  // state carried from one divider cell to the next
  typedef struct packed {
    logic              valid;
    ape_func_t         func;
    logic              bypass;
    logic [T_W-1:0]    t_fix;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] rem;
    logic [FRAC_W-1:0] quo;
  } ape_div_t;

endpackage

>>> src/animation_progress_easing_top.sv
// Top level: progress front end, divider cell chain and easing pipeline.
//
// Usage:
//   in_valid/in_ready/in_data carry one item: curve select, active flag,
//   current time, start time and duration. out_valid/out_ready/out_data
//   return one item per input: clamped progress and eased progress.
//   Progress is (now - start) / span in Q1.16, computed by a row of 16
//   restoring-division cells, one quotient bit per cell; inactive, not yet
//   started and finished items bypass the division with a fixed value.
//   The curve pipeline then takes four stages, the first three with two
//   multipliers each, the last one selecting and saturating.
//   The path from the accepting edge to out_valid holds 21 register
//   stages: 1 front stage, 16 divider cells, 4 curve stages.
//   Throughput: one item per cycle while the receiver does not stall, set
//   by the single shared advance enable of the pipeline.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all stage valid bits; the
//   block is ready in the first cycle after reset is released.
module animation_progress_easing_top
  import ape_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ape_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ape_out_t out_data
);

  logic              en;
  logic [TIME_W-1:0] diff;
  ape_div_t          front_nxt;
  ape_div_t          front_r;
  ape_div_t          chain [DIV_CELLS+1];
  logic [T_W-1:0]    t_div;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    diff = in_data.now_time - in_data.start_time;
    front_nxt.valid  = in_valid;
    front_nxt.func   = in_data.func;
    front_nxt.span   = in_data.span_ms;
    front_nxt.rem    = diff[SPAN_W-1:0];
    front_nxt.quo    = '0;
    front_nxt.bypass = 1'b1;
    front_nxt.t_fix  = ONE;
    if (!in_data.animating) begin
      front_nxt.t_fix = ONE;
    end else if (diff == '0 || diff[TIME_W-1]) begin
      front_nxt.t_fix = '0;
    end else if (diff >= TIME_W'(in_data.span_ms)) begin
      front_nxt.t_fix = ONE;
    end else begin
      front_nxt.bypass = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (en) begin
      front_r <= front_nxt;
    end
  end

  assign chain[0] = front_r;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    ape_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_in  (chain[i]),
      .s_out (chain[i+1])
    );
  end

  assign t_div = chain[DIV_CELLS].bypass ? chain[DIV_CELLS].t_fix
                                         : {1'b0, chain[DIV_CELLS].quo};

  ape_ease u_ease (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (chain[DIV_CELLS].valid),
    .in_func (chain[DIV_CELLS].func),
    .in_t    (t_div),
    .out_vld (out_valid),
    .out_res (out_data)
  );

  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.raw_progress <= ONE)
    else $error("raw progress above one");

  a_end_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.raw_progress == ONE |-> out_data.eased_progress == ONE)
    else $error("eased value at t=1 is not one");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.raw_progress == '0 |-> out_data.eased_progress == '0)
    else $error("eased value at t=0 is not zero");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

endmodule

>>> src/ape_div_cell.sv
// One restoring-division cell: produces one quotient bit per item.
module ape_div_cell
  import ape_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  ape_div_t s_in,
  output ape_div_t s_out
);

  ape_div_t          s_r;
  ape_div_t          s_nxt;
  logic [SPAN_W:0]   rem2;
  logic [SPAN_W:0]   diff;
  logic              ge;

  always_comb begin
    rem2  = {s_in.rem, 1'b0};
    diff  = rem2 - {1'b0, s_in.span};
    ge    = (rem2 >= {1'b0, s_in.span});
    s_nxt = s_in;
    // remainder stays below span, so it fits back into SPAN_W bits
    s_nxt.rem = ge ? diff[SPAN_W-1:0] : rem2[SPAN_W-1:0];
    s_nxt.quo = {s_in.quo[FRAC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

>>> src/ape_ease.sv
// Four-stage curve pipeline: squares, cubes, back terms, select and saturate.
module ape_ease
  import ape_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  ape_func_t      in_func,
  input  logic [T_W-1:0] in_t,
  output logic           out_vld,
  output ape_out_t       out_res
);

  logic [3:0] v_r;

  // stage 1
  ape_func_t       f1_r;
  logic [T_W-1:0]  t1_r, q1_r, t2_r, q2_r;
  logic [T_W-1:0]  q_in;
  logic [2*T_W-1:0] tt, qq;

  // stage 2
  ape_func_t       f2_r;
  logic [T_W-1:0]  t2b_r, q2b_r, t3_r, q3_r;
  logic [2*T_W-1:0] ttt, qqq;

  // stage 3
  ape_func_t       f3_r;
  logic [T_W-1:0]  t3b_r, t3c_r, q3b_r;
  logic [E_W-1:0]  up_r, down_r;
  logic [2*T_W-1:0] c1q2;
  logic [T_W+E_W-1:0] c3q3;

  // stage 4
  logic [E_W-1:0]  r;
  ape_out_t        res_r;

  always_comb begin
    q_in = ONE - in_t;
    tt   = in_t * in_t;
    qq   = q_in * q_in;
    ttt  = t2_r * t1_r;
    qqq  = q2_r * q1_r;
    c1q2 = C1 * q2b_r;
    c3q3 = C3 * q3_r;
  end

  always_comb begin
    case (f3_r)
      FN_LINEAR:    r = {1'b0, t3b_r};
      FN_OUT_CUBIC: r = E_W'(ONE) - {1'b0, q3b_r};
      FN_IN_CUBIC:  r = {1'b0, t3c_r};
      FN_OUT_BACK:  r = (up_r > down_r) ? up_r - down_r : '0;
      default:      r = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= in_func;
      t1_r  <= in_t;
      q1_r  <= q_in;
      t2_r  <= tt[T_W+FRAC_W-1:FRAC_W];
      q2_r  <= qq[T_W+FRAC_W-1:FRAC_W];

      f2_r  <= f1_r;
      t2b_r <= t1_r;
      q2b_r <= q2_r;
      t3_r  <= ttt[T_W+FRAC_W-1:FRAC_W];
      q3_r  <= qqq[T_W+FRAC_W-1:FRAC_W];

      f3_r   <= f2_r;
      t3b_r  <= t2b_r;
      t3c_r  <= t3_r;
      q3b_r  <= q3_r;
      up_r   <= E_W'(ONE) + {1'b0, c1q2[T_W+FRAC_W-1:FRAC_W]};
      down_r <= c3q3[E_W+FRAC_W-1:FRAC_W];

      res_r.raw_progress   <= t3b_r;
      res_r.eased_progress <= (r > EASED_MAX) ? EASED_MAX[T_W-1:0] : r[T_W-1:0];
    end
  end

  assign out_vld = v_r[3];
  assign out_res = res_r;

endmodule
